[hw/rtl/assert_macros.svh]
// Assertion macros used by the allocator RTL.
// Include with the bare file name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[hw/rtl/ffra_pkg.sv]
// Package for the first-fit region allocator: widths, codes and FSM states.
// No dependencies.
package ffra_pkg;
    localparam int MaxSegments = 64;
    localparam int IdxW = $clog2(MaxSegments);
    localparam int CntW = IdxW + 1;
    localparam int AddrW = 32;
    localparam logic [31:0] PoolReset = 32'd67108864;

    localparam logic [1:0] StOk = 2'd0;
    localparam logic [1:0] StNoFit = 2'd1;
    localparam logic [1:0] StFull = 2'd2;
    localparam logic [1:0] StZero = 2'd3;

    localparam logic ActAlloc = 1'b0;
    localparam logic ActFree = 1'b1;

    localparam logic [0:0] RegPoolSize = 1'd0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ARD,   // alloc scan: memory read in flight
        S_ACHK,  // alloc scan: compare
        S_RRD,   // free: right-neighbor scan read
        S_RCHK,
        S_LRD,   // free: left-neighbor scan read
        S_LCHK,
        S_SHRD,  // shift read
        S_SHWR,  // shift write
        S_FIN,   // read entry 0 for the all-free flag
        S_FIN2,
        S_OUT
    } t_state;
endpackage

[hw/rtl/ffra_if.sv]
// Valid/ready channel interfaces for the allocator's request and response.
// Depends on nothing.
interface ffra_req_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [31:0] req_size;
    logic [31:0] block_offset;
    modport source (output valid, action, req_size, block_offset, input ready);
    modport sink (input valid, action, req_size, block_offset, output ready);
endinterface

interface ffra_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] granted_offset;
    logic [31:0] granted_size;
    logic        pool_all_free;
    modport source (output valid, status, granted_offset, granted_size, pool_all_free,
        input ready);
    modport sink (input valid, status, granted_offset, granted_size, pool_all_free,
        output ready);
endinterface

[hw/rtl/ffra_seg_ram.sv]
// Segment table memory: one write port and one registered read port.
// Depends on ffra_pkg.
module ffra_seg_ram (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [ffra_pkg::IdxW-1:0] i_waddr,
    input  logic [63:0]            i_wdata,
    input  logic [ffra_pkg::IdxW-1:0] i_raddr,
    output logic [63:0]            o_rdata
);
    import ffra_pkg::*;

    // Each word holds {length, offset}.
    logic [63:0] r_mem [MaxSegments];
    logic [63:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[hw/rtl/first_fit_region_allocator.sv]
// First-fit region allocator with coalescing on free (top level).
// Uses ffra_pkg, ffra_if.sv, ffra_seg_ram and assert_macros.svh.
//
// The request channel carries one word: an action (allocate or free), a size
// and, for free, an offset. The response channel returns one word per request
// with a status, the granted offset and size, and a flag that is set when a
// single free segment covers the whole pool.
// The free-segment table lives in a 64-entry memory with one read and one
// write port; a small sequencer walks it one entry at a time, a read and then
// a compare for each. An allocate scans entries until one fits; a free scans
// for a right neighbor and then for a left neighbor. A removal moves the later
// entries down, and an insert moves them up and writes the new head. A zero
// size skips the scan. The worst case is a free that is inserted into a table
// of 63 segments. Only one word is worked on at a time; the request ready is
// low from acceptance until the response is taken. A stalled response just
// holds, and the next word waits until it is taken.
// Reset (or a write of pool_size over APB at address 0) sets the count to one
// at once and writes entry 0 as (0, pool_size) in the following cycle, so no
// clearing pass is needed. APB writes are expected only while idle.
module first_fit_region_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ffra_req_if.sink    i_req,
    ffra_rsp_if.source  o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ffra_pkg::*;
    `include "assert_macros.svh"

    t_state r_state, n_state;

    logic [31:0]     r_pool;
    logic [CntW-1:0] r_cnt;
    logic [IdxW-1:0] r_idx;       // scan index
    logic [IdxW-1:0] r_j;         // merged (right) entry index
    logic            r_act;
    logic [31:0]     r_size, r_off;
    logic [31:0]     r_joff, r_jlen; // merged segment value
    logic [1:0]      r_status;
    logic [31:0]     r_goff, r_gsize;
    logic            r_allfree;
    logic            r_shup;      // shift direction: 1 insert (move up)
    logic            r_rsp_valid;
    logic            r_init;      // entry 0 is rewritten this cycle

    // Memory port signals.
    logic            m_we;
    logic [IdxW-1:0] m_waddr, m_raddr;
    logic [63:0]     m_wdata, m_rdata;

    ffra_seg_ram u_ram (
        .i_clk  (i_clk),
        .i_we   (m_we),
        .i_waddr(m_waddr),
        .i_wdata(m_wdata),
        .i_raddr(m_raddr),
        .o_rdata(m_rdata)
    );

    logic [31:0] rd_off, rd_len, rd_end;
    assign rd_off = m_rdata[31:0];
    assign rd_len = m_rdata[63:32];
    assign rd_end = rd_off + rd_len;

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegPoolSize);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == RegPoolSize) ? r_pool : 32'd0;

    logic req_fire, rsp_fire, last;
    assign req_fire = i_req.valid && i_req.ready;
    assign rsp_fire = r_rsp_valid && o_rsp.ready;
    assign last = ({1'b0, r_idx} + 1'b1) >= r_cnt;
    assign i_req.ready = (r_state == S_IDLE);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (req_fire) begin
                if (i_req.req_size == 32'd0) n_state = S_FIN;
                else if (i_req.action == ActAlloc)
                    n_state = (r_cnt == '0) ? S_FIN : S_ARD;
                else n_state = (r_cnt == '0) ? S_LRD : S_RRD;
            end
            S_ARD:  n_state = S_ACHK;
            S_ACHK: begin
                if (rd_len >= r_size)
                    n_state = (rd_len > r_size || last) ? S_FIN : S_SHRD;
                else n_state = last ? S_FIN : S_ARD;
            end
            S_RRD:  n_state = S_RCHK;
            S_RCHK: begin
                if (rd_off == r_size + r_off) n_state = S_LRD;
                else n_state = last ? S_LRD : S_RRD;
            end
            S_LRD:  n_state = (r_cnt == '0) ? S_SHRD : S_LCHK;
            S_LCHK: begin
                n_state = S_FIN;
                if (r_cnt != '0) begin
                    if (!(r_act && r_j == r_idx) && rd_end == (r_act ? r_joff : r_off))
                        n_state = (r_act && !last) ? S_SHRD : S_FIN;
                    else if (!last)
                        n_state = S_LRD;
                    else if (!r_act)
                        n_state = (r_cnt == CntW'(MaxSegments)) ? S_FIN : S_SHRD;
                end
            end
            S_SHRD: n_state = S_SHWR;
            S_SHWR: n_state = ((r_shup && r_idx == '0) ||
                (!r_shup && ({1'b0, r_idx} + 2'd2) >= r_cnt)) ? S_FIN : S_SHRD;
            S_FIN:  n_state = S_FIN2;
            S_FIN2: n_state = S_OUT;
            S_OUT:  n_state = rsp_fire ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs and datapath: memory addressing and writes.
    always_comb begin
        m_we = 1'b0;
        m_waddr = r_idx;
        m_wdata = {rd_len, rd_off};
        m_raddr = r_idx;
        unique case (r_state)
            S_ACHK: if (rd_len > r_size) begin
                m_we = 1'b1;
                m_wdata = {rd_len - r_size, rd_off + r_size};
            end
            S_RCHK: if (rd_off == r_size + r_off) begin
                m_we = 1'b1;
                m_wdata = {rd_len + r_size, r_off};
            end
            S_LCHK: if (r_cnt != '0 && !(r_act && r_j == r_idx) &&
                rd_end == (r_act ? r_joff : r_off)) begin
                m_we = 1'b1;
                if (r_act) begin
                    m_waddr = r_j;
                    m_wdata = {r_jlen + rd_len, rd_off};
                end else begin
                    m_wdata = {rd_len + r_size, rd_off};
                end
            end
            S_SHRD: m_raddr = r_shup ? r_idx - 1'b1 : r_idx + 1'b1;
            S_SHWR: begin
                m_we = 1'b1;
                m_wdata = (r_shup && r_idx == '0) ? {r_size, r_off} : m_rdata;
            end
            S_FIN: m_raddr = '0;
            default: ;
        endcase
        // Port free: idle after reset, and the user writes pool_size only while idle.
        if (r_init) begin
            m_we = 1'b1;
            m_waddr = '0;
            m_wdata = {r_pool, 32'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pool <= PoolReset;
            r_cnt <= CntW'(1);
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                r_pool <= pwdata;
                r_cnt <= CntW'(1);
            end
            if (r_state == S_FIN2) r_rsp_valid <= 1'b1;
            if (rsp_fire) r_rsp_valid <= 1'b0;
            if (r_state == S_SHWR && r_shup && r_idx == '0) r_cnt <= r_cnt + 1'b1;
            if (r_state == S_SHWR && !r_shup && ({1'b0, r_idx} + 2'd2) >= r_cnt)
                r_cnt <= r_cnt - 1'b1;
            if (r_state == S_ACHK && rd_len == r_size && last) r_cnt <= r_cnt - 1'b1;
            if (r_state == S_LCHK && r_act && r_cnt != '0 && r_j != r_idx &&
                rd_end == r_joff && last) r_cnt <= r_cnt - 1'b1;
        end
    end

    // Entry 0 of the table is written as (0, pool) in the cycle after reset
    // or after a pool_size write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_init <= 1'b1;
        else r_init <= cfg_wr;
    end

    // Payload and scan registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_size <= i_req.req_size;
                r_off <= i_req.block_offset;
                r_idx <= '0;
                r_goff <= '0;
                r_gsize <= '0;
                r_status <= (i_req.req_size == 32'd0) ? StZero :
                    (i_req.action == ActAlloc && r_cnt == '0) ? StNoFit : StOk;
                r_act <= 1'b0;
            end
            S_ACHK: begin
                if (rd_len >= r_size) begin
                    r_goff <= rd_off;
                    r_gsize <= r_size;
                    r_shup <= 1'b0;
                end else if (last) begin
                    r_status <= StNoFit;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            S_RCHK: begin
                if (rd_off == r_size + r_off) begin
                    r_act <= 1'b1;
                    r_j <= r_idx;
                    r_joff <= r_off;
                    r_jlen <= rd_len + r_size;
                    r_idx <= '0;
                end else if (last) begin
                    r_idx <= '0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            S_LCHK: begin
                if (r_cnt != '0 && !(r_act && r_j == r_idx) &&
                    rd_end == (r_act ? r_joff : r_off)) begin
                    r_shup <= 1'b0;
                end else if (!last) begin
                    r_idx <= r_idx + 1'b1;
                end else if (!r_act) begin
                    if (r_cnt == CntW'(MaxSegments)) r_status <= StFull;
                    else begin
                        r_shup <= 1'b1;
                        r_idx <= IdxW'(r_cnt);
                    end
                end
            end
            S_LRD: if (r_cnt == '0) begin
                r_shup <= 1'b1;
            end
            S_SHWR: r_idx <= r_shup ? r_idx - 1'b1 : r_idx + 1'b1;
            S_FIN2: r_allfree <= (r_cnt == CntW'(1)) && (rd_len == r_pool);
            default: ;
        endcase
    end

    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.status = r_status;
    assign o_rsp.granted_offset = r_goff;
    assign o_rsp.granted_size = r_gsize;
    assign o_rsp.pool_all_free = r_allfree;

    `ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, i_req.ready, !r_rsp_valid,
        "request ready while a response is pending")
    `ASSERT_NEXT(a_fin_valid, i_clk, i_rst_n, r_state == S_FIN2, r_rsp_valid,
        "response not raised after finish")
    `ASSERT_IMP(a_cnt_max, i_clk, i_rst_n, 1'b1, r_cnt <= CntW'(MaxSegments),
        "segment count above table depth")
    `ASSERT_IMP(a_init_idle, i_clk, i_rst_n, r_init, r_state == S_IDLE,
        "entry zero written while a word is in flight")
endmodule

[verif/tb.sv]
// Self-checking testbench for first_fit_region_allocator.
// Depends on ffra_pkg, the channel interfaces in ffra_if.sv and the allocator RTL.
`timescale 1ns / 1ps
module tb;
    import ffra_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    ffra_req_if req_ch ();
    ffra_rsp_if rsp_ch ();

    first_fit_region_allocator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10 i_clk = ~i_clk;

    // One expected response word.
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] goff;
        logic [31:0] gsize;
        logic        all_free;
    } t_rsp;

    // Shadow copy of the free-segment table and the pool size.
    logic [31:0] shadow_off [MaxSegments];
    logic [31:0] shadow_len [MaxSegments];
    int          shadow_cnt;
    logic [31:0] shadow_pool;

    // Live allocations, kept so that frees can return real blocks.
    logic [31:0] live_off [$];
    logic [31:0] live_len [$];

    t_rsp pending_rsp [$];
    int   mismatches = 0;

    function automatic void shadow_reset(input logic [31:0] pool);
        shadow_pool = pool;
        shadow_cnt = 1;
        shadow_off[0] = '0;
        shadow_len[0] = pool;
        live_off.delete();
        live_len.delete();
    endfunction

    function automatic void drop_segment(input int k);
        for (int i = k; i + 1 < shadow_cnt; i++) begin
            shadow_off[i] = shadow_off[i + 1];
            shadow_len[i] = shadow_len[i + 1];
        end
        shadow_cnt--;
    endfunction

    // Applies one request to the shadow table and returns the expected word.
    function automatic t_rsp predict_alloc_free(input logic act, input logic [31:0] sz,
                                                input logic [31:0] off);
        t_rsp r;
        logic [31:0] blk_end;
        bit done;
        r = '0;
        done = 0;
        blk_end = off + sz;
        if (sz == 0) begin
            r.status = StZero;
        end else if (act == ActAlloc) begin
            r.status = StNoFit;
            for (int i = 0; i < shadow_cnt && !done; i++) begin
                if (shadow_len[i] >= sz) begin
                    r.status = StOk;
                    r.goff = shadow_off[i];
                    r.gsize = sz;
                    if (shadow_len[i] > sz) begin
                        shadow_off[i] = shadow_off[i] + sz;
                        shadow_len[i] = shadow_len[i] - sz;
                    end else begin
                        drop_segment(i);
                    end
                    done = 1;
                end
            end
        end else begin
            r.status = StOk;
            // Merge into a right neighbor, then try to absorb a left one.
            for (int j = 0; j < shadow_cnt && !done; j++) begin
                if (shadow_off[j] == blk_end) begin
                    shadow_off[j] = off;
                    shadow_len[j] = shadow_len[j] + sz;
                    done = 1;
                    for (int k = 0; k < shadow_cnt; k++) begin
                        if (k != j && shadow_off[k] + shadow_len[k] == shadow_off[j]) begin
                            shadow_off[j] = shadow_off[k];
                            shadow_len[j] = shadow_len[j] + shadow_len[k];
                            drop_segment(k);
                            break;
                        end
                    end
                end
            end
            for (int k = 0; k < shadow_cnt && !done; k++) begin
                if (shadow_off[k] + shadow_len[k] == off) begin
                    shadow_len[k] = shadow_len[k] + sz;
                    done = 1;
                end
            end
            if (!done) begin
                if (shadow_cnt >= MaxSegments) begin
                    r.status = StFull;
                end else begin
                    for (int k = shadow_cnt; k > 0; k--) begin
                        shadow_off[k] = shadow_off[k - 1];
                        shadow_len[k] = shadow_len[k - 1];
                    end
                    shadow_off[0] = off;
                    shadow_len[0] = sz;
                    shadow_cnt++;
                end
            end
        end
        r.all_free = (shadow_cnt == 1 && shadow_len[0] == shadow_pool);
        return r;
    endfunction

    // Sends one word after a random gap and records what it must produce.
    task automatic send_word(input logic act, input logic [31:0] sz, input logic [31:0] off);
        t_rsp r;
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
        repeat (gap) @(posedge i_clk);
        req_ch.valid <= 1'b1;
        req_ch.action <= act;
        req_ch.req_size <= sz;
        req_ch.block_offset <= off;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        r = predict_alloc_free(act, sz, off);
        if (act == ActAlloc && r.status == StOk) begin
            live_off = {live_off, r.goff};
            live_len = {live_len, r.gsize};
        end
        pending_rsp = {pending_rsp, r};
        req_ch.valid <= 1'b0;
        // The block stays busy after acceptance anyway, until the response is taken.
        @(posedge i_clk);
    endtask

    // Waits until every response is in, then lets the sequencer settle.
    task automatic drain;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    // APB write of pool_size; only issued while the block is idle.
    task automatic write_pool_size(input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {RegPoolSize, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        shadow_reset(val);
    endtask

    // Response sink: random stalls, compared field by field in order.
    always @(posedge i_clk) begin
        t_rsp exp_r;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected response word");
            end else begin
                exp_r = pending_rsp.pop_front();
                if (rsp_ch.status !== exp_r.status || rsp_ch.granted_offset !== exp_r.goff ||
                    rsp_ch.granted_size !== exp_r.gsize ||
                    rsp_ch.pool_all_free !== exp_r.all_free) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp st=%0d off=%h sz=%h af=%b %s",
                                 exp_r.status, exp_r.goff, exp_r.gsize, exp_r.all_free,
                                 $sformatf("got st=%0d off=%h sz=%h af=%b",
                                           rsp_ch.status, rsp_ch.granted_offset,
                                           rsp_ch.granted_size, rsp_ch.pool_all_free));
                end
            end
        end
    end

    // Ready is drawn per word: a random stall, often none.
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (rsp_ch.valid && rsp_ch.ready) begin
            stall_left = $urandom_range(0, 1) ? 0 : $urandom_range(0, 16);
            rsp_ch.ready <= (stall_left == 0);
        end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= (stall_left == 0);
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // Directed: zero sizes, extremes, exact fit, all four free paths, no fit.
    task automatic test_directed;
        send_word(ActAlloc, 32'd0, 32'hFFFF_FFFF);
        send_word(ActFree, 32'd0, 32'd5);
        send_word(ActAlloc, 32'hFFFF_FFFF, 32'd0);
        send_word(ActAlloc, 32'd1, 32'hFFFF_FFFF);
        send_word(ActAlloc, 32'd16, 32'd0);
        send_word(ActAlloc, 32'd32, 32'd0);
        send_word(ActFree, 32'd16, 32'd1);      // no neighbor: inserted at the head
        send_word(ActFree, 32'd32, 32'd17);     // right neighbor, then absorb left
        send_word(ActFree, 32'd1, 32'd0);       // right merge only; pool is all free
        send_word(ActAlloc, PoolReset, 32'd0);  // exact fit empties the table
        send_word(ActAlloc, 32'd1, 32'd0);      // nothing fits on an empty table
        send_word(ActFree, 32'd100, 32'd0);     // insert into an empty table
        send_word(ActFree, 32'd100, 32'd100);   // extends a left neighbor
        send_word(ActFree, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();
        // Zero pool never fits; a pool of all ones wraps sums around.
        write_pool_size(32'd0);
        send_word(ActAlloc, 32'd1, 32'd0);
        drain();
        write_pool_size(32'hFFFF_FFFF);
        send_word(ActAlloc, 32'hFFFF_FFFE, 32'd0);
        send_word(ActFree, 32'd2, 32'hFFFF_FFFF);
        send_word(ActAlloc, 32'h8000_0000, 32'hAAAA_5555);
        drain();
    endtask

    // Fills the table: many small frees of isolated blocks until it is full.
    task automatic test_table_full;
        write_pool_size(32'd1);
        for (int i = 0; i < MaxSegments + 3; i++)
            send_word(ActFree, 32'd1, 32'd1000 + 3 * i);
        for (int i = 0; i < 4; i++) send_word(ActAlloc, 32'd1, 32'd0);
        drain();
    endtask

    // Random mix: mostly allocations and frees of real blocks, some noise.
    task automatic test_random(input logic [31:0] pool, input int n);
        logic [31:0] sz, off;
        int pick;
        write_pool_size(pool);
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                sz = $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(1, pool / 16 + 1);
                send_word(ActAlloc, sz, $urandom);
            end else if (pick < 88 && live_off.size() != 0) begin
                pick = $urandom_range(0, live_off.size() - 1);
                off = live_off[pick];
                sz = live_len[pick];
                live_off.delete(pick);
                live_len.delete(pick);
                send_word(ActFree, sz, off);
            end else begin
                send_word(1'($urandom_range(0, 1)),
                          $urandom_range(0, 3) == 0 ? 32'd0 : $urandom, $urandom);
            end
        end
        drain();
    endtask

    initial begin
        req_ch.valid <= 1'b0;
        req_ch.action <= ActAlloc;
        req_ch.req_size <= '0;
        req_ch.block_offset <= '0;
        shadow_reset(PoolReset);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_table_full();
        test_random(32'd4096, 600);
        test_random(32'd300, 500);
        test_random(32'hFFFF_FFFF, 500);
        if (mismatches == 0 && pending_rsp.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #80ms;
        $display("status: fail");
        $finish;
    end
endmodule

[first_fit_region_allocator.f]
+incdir+hw/rtl
hw/rtl/ffra_pkg.sv
hw/rtl/ffra_if.sv
hw/rtl/ffra_seg_ram.sv
hw/rtl/first_fit_region_allocator.sv
verif/tb.sv
